### src/sdft_pkg.sv
// Shared types and constants for the sliding DFT bin magnitude block.
package sdft_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned BinW    = 48;
  localparam int unsigned TwW     = 36;
  localparam int unsigned CsW     = 18;
  localparam int unsigned MagW    = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 36;
  localparam int unsigned FracW   = 16;

  localparam logic [CfgIdxW-1:0] CfgWindow = 3'd0;
  // highest index that can hold a twiddle
  localparam logic [CfgIdxW-1:0] CfgTwLast = 3'd4;

  localparam logic [TwW-1:0] TwReset = 36'h4_0000_0000;

  localparam logic signed [BinW-1:0] BinMax = {1'b0, {(BinW-1){1'b1}}};
  localparam logic signed [BinW-1:0] BinMin = {1'b1, {(BinW-1){1'b0}}};
  localparam logic [MagW-1:0] MagMax = '1;

  // token handed from one bin cell to the next
  typedef struct packed {
    logic                    vld;
    logic signed [17:0]      diff;
  } sdft_tok_t;

  // magnitude request from a cell
  typedef struct packed {
    logic                   vld;
    logic signed [BinW-1:0] re;
    logic signed [BinW-1:0] im;
  } sdft_mreq_t;

  function automatic logic signed [BinW-1:0] sat48(input logic signed [BinW+2:0] v);
    if (v > $signed({3'b000, BinMax})) return BinMax;
    if (v < $signed({3'b111, BinMin})) return BinMin;
    return v[BinW-1:0];
  endfunction

endpackage

### src/sdft_cell.sv
// One bin cell: holds one bin's state, adds the sample difference and rotates.
module sdft_cell
  import sdft_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clr_i,
  input  logic [TwW-1:0]         twiddle_i,
  input  sdft_tok_t              tok_i,
  output sdft_tok_t              tok_o,
  output sdft_mreq_t             mreq_o
);

  localparam int unsigned PW = BinW + CsW + 1;

  localparam logic [2:0] StIdle = 3'd0, StAdd = 3'd1, StMulA = 3'd2, StMulB = 3'd3,
                         StDone = 3'd4;

  logic [2:0] step_q, step_d;
  logic signed [BinW-1:0] re_q, im_q, ra_q, im_nx;
  logic signed [17:0]     diff_q;
  logic signed [CsW-1:0]  c, s;
  // full products of bin and twiddle
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [BinW+CsW+1:0] sr, si;
  logic signed [BinW+2:0] nr, ni, radd;
  sdft_tok_t tok_q;
  sdft_mreq_t mreq_q;

  assign c = twiddle_i[TwW-1:CsW];
  assign s = twiddle_i[CsW-1:0];
  assign radd = $signed({{3{re_q[BinW-1]}}, re_q})
              + $signed({{(BinW-FracW-15){diff_q[17]}}, diff_q, {FracW{1'b0}}});
  assign sr = $signed({p0_q[BinW+CsW], p0_q}) - $signed({p1_q[BinW+CsW], p1_q});
  assign si = $signed({p2_q[BinW+CsW], p2_q}) + $signed({p3_q[BinW+CsW], p3_q});
  // arithmetic shift floors toward minus infinity
  assign nr = (BinW+3)'(sr >>> FracW);
  assign ni = (BinW+3)'(si >>> FracW);
  assign im_nx = sat48(ni);

  always_comb begin
    step_d = step_q;
    unique case (step_q)
      StIdle: if (tok_i.vld) step_d = StAdd;
      StAdd:  step_d = StMulA;
      StMulA: step_d = StMulB;
      StMulB: step_d = StDone;
      StDone: step_d = StIdle;
      default: step_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle;
      re_q   <= '0;
      im_q   <= '0;
      tok_q  <= '0;
      mreq_q <= '0;
    end else begin
      step_q     <= clr_i ? StIdle : step_d;
      tok_q.vld  <= !clr_i && (step_q == StDone);
      tok_q.diff <= diff_q;
      mreq_q.vld <= !clr_i && (step_q == StDone);
      mreq_q.re  <= re_q;
      mreq_q.im  <= im_nx;
      if (clr_i) begin
        re_q <= '0;
        im_q <= '0;
      end else if (step_q == StMulB) begin
        re_q <= sat48(nr);
      end else if (step_q == StDone) begin
        im_q <= im_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_q == StIdle && tok_i.vld) diff_q <= tok_i.diff;
    if (step_q == StAdd) ra_q <= sat48(radd);
    if (step_q == StMulA) begin
      p0_q <= PW'(ra_q) * PW'(c);
      p1_q <= PW'(im_q) * PW'(s);
    end
    if (step_q == StMulB) begin
      p2_q <= PW'(ra_q) * PW'(s);
      p3_q <= PW'(im_q) * PW'(c);
    end
  end

  assign tok_o  = tok_q;
  assign mreq_o = mreq_q;

endmodule

### src/sdft_mag.sv
// Magnitude unit: squares in pieces, then a bit-serial square root.
module sdft_mag
  import sdft_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [BinW-1:0] re_i,
  input  logic signed [BinW-1:0] im_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [MagW-1:0]        mag_o
);

  localparam logic [2:0] SIdle = 3'd0, SSq = 3'd1, SRoot = 3'd2, SOut = 3'd3;

  logic [2:0]  st_q;
  logic [47:0] ar_q, ai_q;
  logic [1:0]  ph_q;
  logic [96:0] acc_q;
  logic [63:0] x_q, r_q;
  logic [5:0]  cnt_q;
  logic [63:0] bit_v, trial;
  logic [23:0] a_part;
  logic [47:0] a_full;
  logic [71:0] pp;

  assign bit_v  = 64'd1 << {cnt_q, 1'b0};
  assign trial  = r_q + bit_v;
  // square by 24-bit slices: x*x = sum over slices
  assign a_full = ph_q[1] ? ai_q : ar_q;
  assign a_part = ph_q[0] ? a_full[47:24] : a_full[23:0];
  assign pp     = 72'(a_full) * 72'(a_part);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SIdle;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (st_q)
        SIdle: if (start_i) begin
          ar_q  <= re_i[BinW-1] ? 48'(-re_i) : 48'(re_i);
          ai_q  <= im_i[BinW-1] ? 48'(-im_i) : 48'(im_i);
          ph_q  <= 2'd0;
          acc_q <= '0;
          st_q  <= SSq;
        end
        SSq: begin
          acc_q <= acc_q + (ph_q[0] ? {1'b0, pp, 24'd0} : {25'd0, pp});
          ph_q  <= ph_q + 2'd1;
          if (ph_q == 2'd3) st_q <= SRoot;
          cnt_q <= 6'd31;
          r_q   <= '0;
        end
        SRoot: begin
          ph_q <= 2'd1;
          if (ph_q == 2'd0) begin
            x_q <= acc_q[95:32];
          end else begin
            if (x_q >= trial) begin
              x_q <= x_q - trial;
              r_q <= (r_q >> 1) + bit_v;
            end else begin
              r_q <= r_q >> 1;
            end
            cnt_q <= cnt_q - 6'd1;
            if (cnt_q == 6'd0) st_q <= SOut;
          end
        end
        SOut: begin
          mag_o  <= (r_q > 64'(MagMax)) ? MagMax : r_q[MagW-1:0];
          done_o <= 1'b1;
          st_q   <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  assign busy_o = (st_q != SIdle);

endmodule

### src/sliding_dft_bin_magnitudes_core.sv
// Sliding DFT core: sample ring, chain of bin cells, magnitude unit, result queue.
//
// Use: write config (window_size at index 0, twiddles at 1..BIN_COUNT) while idle.
// A valid window_size write (1..WINDOW_MAX) clears ring and bins with a ring
// sweep during which no sample is accepted. After reset the same sweep runs.
// Each accepted sample yields BIN_COUNT results, bins in order, last_bin_o on
// the final one. The ring is read first; each bin cell then adds and rotates
// and hands the difference to its neighbor; every bin magnitude is computed by
// one shared unit, one bin at a time (start, squaring, load, 32 root steps,
// output, handoff). The next sample is taken only after the shared square
// root has finished every bin of the previous one.
// Results wait in a BIN_COUNT-deep queue; no new sample is taken until the
// queue is empty, so a stalled receiver stalls the input and no result is lost.
module sliding_dft_bin_magnitudes_core
  import sdft_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = 256,
  parameter int unsigned BIN_COUNT  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SampleW-1:0]   sample_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           bin_index_o,
  output logic [MagW-1:0]      magnitude_o,
  output logic                 last_bin_o
);

  localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned BW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int unsigned WSW = AW + 1;

  localparam logic [2:0] SClr = 3'd0, SIdle = 3'd1, SRd = 3'd2, SDiff = 3'd3,
                         SRun = 3'd4, SDrain = 3'd5;

  logic [2:0]          st_q;
  logic [AW:0]         clr_cnt_q;
  logic [AW-1:0]       wpos_q;
  logic [WSW-1:0]      wsize_q;
  logic [TwW-1:0]      tw_q [BIN_COUNT];
  logic [SampleW-1:0]  ring [WINDOW_MAX];
  logic [SampleW-1:0]  rd_q, smp_q;
  logic                clr_bins;
  logic [8:0]          nw;
  logic                wr_ok;

  sdft_tok_t  tok [BIN_COUNT+1];
  sdft_mreq_t mreq [BIN_COUNT];
  sdft_tok_t  tok0_q;

  // magnitude arbitration: cells finish in order; requests queue
  logic signed [BinW-1:0] pre_q [BIN_COUNT], pim_q [BIN_COUNT];
  logic [BIN_COUNT-1:0]   pend_q, pend_d;
  logic [BW-1:0]          mag_bin_q;
  logic                   mag_start, mag_busy, mag_done;
  logic [MagW-1:0]        mag_val;
  logic [BW:0]            mag_cnt_q;

  // result queue
  logic [MagW-1:0] fq_mag [BIN_COUNT];
  logic [BW-1:0]   fq_bin [BIN_COUNT];
  logic [BW-1:0]   fq_rd_q, fq_wr_q;
  logic [BW:0]     fq_n_q;

  assign nw    = cfg_data_i[8:0];
  assign wr_ok = cfg_valid_i && cfg_index_i == CfgWindow && nw != 9'd0
                 && 32'(nw) <= WINDOW_MAX;
  assign cfg_ready_o = 1'b1;
  // a window write restarts the sweep, so no sample is taken in that cycle
  assign in_ready_o  = (st_q == SIdle) && !wr_ok;
  assign clr_bins    = wr_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= WSW'(WINDOW_MAX);
      for (int i = 0; i < BIN_COUNT; i++) tw_q[i] <= TwReset;
    end else if (cfg_valid_i) begin
      if (wr_ok) wsize_q <= WSW'(nw);
      for (int i = 0; i < BIN_COUNT; i++)
        if (32'(cfg_index_i) == i + 1 && cfg_index_i <= CfgTwLast) tw_q[i] <= cfg_data_i;
    end
  end

  // ring memory
  always_ff @(posedge clk_i) begin
    if (st_q == SClr) ring[clr_cnt_q[AW-1:0]] <= '0;
    else if (st_q == SDiff) ring[wpos_q] <= smp_q;
    rd_q <= ring[wpos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= SClr;
      clr_cnt_q <= '0;
      wpos_q    <= '0;
      mag_cnt_q <= '0;
    end else begin
      if (wr_ok) begin
        st_q      <= SClr;
        clr_cnt_q <= '0;
        wpos_q    <= '0;
      end else begin
        unique case (st_q)
          SClr: begin
            clr_cnt_q <= clr_cnt_q + 1'b1;
            if (32'(clr_cnt_q) == WINDOW_MAX - 1) st_q <= SIdle;
          end
          SIdle: if (in_valid_i) begin
            smp_q <= sample_i;
            st_q  <= SRd;
          end
          SRd: st_q <= SDiff;
          SDiff: begin
            wpos_q <= ({1'b0, wpos_q} + 1'b1 >= (AW+1)'(wsize_q)) ? '0 : wpos_q + 1'b1;
            mag_cnt_q <= '0;
            st_q <= SRun;
          end
          SRun: begin
            if (mag_done) mag_cnt_q <= mag_cnt_q + 1'b1;
            if (mag_done && 32'(mag_cnt_q) == BIN_COUNT - 1) st_q <= SDrain;
          end
          SDrain: if (fq_n_q == '0) st_q <= SIdle;
          default: st_q <= SIdle;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_q <= '0;
    end else begin
      tok0_q.vld  <= !wr_ok && (st_q == SDiff);
      tok0_q.diff <= $signed({2'b00, smp_q}) - $signed({2'b00, rd_q});
    end
  end

  assign tok[0] = tok0_q;

  for (genvar g = 0; g < BIN_COUNT; g++) begin : g_cell
    sdft_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clr_i     (clr_bins),
      .twiddle_i (tw_q[g]),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1]),
      .mreq_o    (mreq[g])
    );
  end

  assign mag_start = !mag_busy && pend_q[mag_bin_q];

  always_comb begin
    pend_d = pend_q;
    for (int i = 0; i < BIN_COUNT; i++)
      if (mreq[i].vld) pend_d[i] = 1'b1;
    if (mag_start) pend_d[mag_bin_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      mag_bin_q <= '0;
    end else begin
      pend_q <= pend_d;
      if (mag_done)
        mag_bin_q <= (32'(mag_bin_q) == BIN_COUNT - 1) ? '0 : mag_bin_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < BIN_COUNT; i++)
      if (mreq[i].vld) begin
        pre_q[i] <= mreq[i].re;
        pim_q[i] <= mreq[i].im;
      end
  end

  sdft_mag u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mag_start),
    .re_i    (pre_q[mag_bin_q]),
    .im_i    (pim_q[mag_bin_q]),
    .busy_o  (mag_busy),
    .done_o  (mag_done),
    .mag_o   (mag_val)
  );

  // result queue, written in bin order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fq_rd_q <= '0;
      fq_wr_q <= '0;
      fq_n_q  <= '0;
    end else begin
      if (mag_done)
        fq_wr_q <= (32'(fq_wr_q) == BIN_COUNT - 1) ? '0 : fq_wr_q + 1'b1;
      if (out_valid_o && out_ready_i)
        fq_rd_q <= (32'(fq_rd_q) == BIN_COUNT - 1) ? '0 : fq_rd_q + 1'b1;
      fq_n_q <= fq_n_q + (mag_done ? 1'b1 : 1'b0) - ((out_valid_o && out_ready_i) ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mag_done) begin
      fq_mag[fq_wr_q] <= mag_val;
      fq_bin[fq_wr_q] <= mag_bin_q;
    end
  end

  assign out_valid_o = (fq_n_q != '0);
  assign bin_index_o = 2'(fq_bin[fq_rd_q]);
  assign magnitude_o = fq_mag[fq_rd_q];
  assign last_bin_o  = (32'(fq_bin[fq_rd_q]) == BIN_COUNT - 1);

endmodule
